FILE: rtl/q24_8_fixed_point_alu_assert.svh
// Assertion macros shared by the fixed-point ALU files.
`ifndef Q24_8_FIXED_POINT_ALU_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define Q248_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define Q248_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/q248alu_pkg.sv
package q248alu_pkg;

    localparam int FRAC_BITS      = 8;
    localparam int DATA_W         = 32;
    // 2*(|a| << F) + |b| fits in DATA_W + F + 2 bits
    localparam int NUM_W          = DATA_W + FRAC_BITS + 2;
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = (NUM_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int NUM_PAD_W      = DIV_STAGES * BITS_PER_STAGE;
    localparam int DEN_W          = DATA_W + 1;
    localparam int WIDE_W         = 64;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_INC      = 4'd4,
        OP_DEC      = 4'd5,
        OP_MIN      = 4'd6,
        OP_MAX      = 4'd7,
        OP_TO_INT   = 4'd8,
        OP_FROM_INT = 4'd9
    } op_t;

    typedef struct packed {
        logic [3:0]               req_type;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     is_less;
        logic                     is_equal;
        logic                     is_greater;
        logic                     overflow;
        logic                     divide_by_zero;
    } rsp_t;

    // Divider working set, one per stage
    typedef struct packed {
        logic [NUM_PAD_W-1:0] num;
        logic [DEN_W-1:0]     den;
        logic [DEN_W-1:0]     rem;
        logic [NUM_PAD_W-1:0] quo;
    } div_state_t;

    // Side band carried alongside the divider
    typedef struct packed {
        logic [3:0]               op;
        logic                     neg;
        logic                     lt;
        logic                     eq;
        logic                     gt;
        logic signed [DATA_W-1:0] res;
        logic                     ovf;
        logic                     dz;
    } sb_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } sat_t;

    function automatic sat_t saturate(input logic signed [WIDE_W-1:0] v);
        sat_t s;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            s.val = DATA_W'(hi);
            s.ovf = 1'b1;
        end else if (v < lo) begin
            s.val = DATA_W'(lo);
            s.ovf = 1'b1;
        end else begin
            s.val = DATA_W'(v);
            s.ovf = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: rtl/q24_8_fixed_point_alu.sv
// Signed Q24.8 fixed-point ALU.
// Input channel: present an item on req and raise start; it transfers at the
// rising edge where start is high and busy is low. busy is never raised, so
// one item may transfer on every cycle.
// Output channel: each item yields exactly one result on rsp, marked by done
// for a single cycle; the result transfers at the edge ending that cycle.
// The receiver cannot stall, and none is needed: the pipeline never holds.
// Every operation takes the same path length so results leave in order.
// Throughput: one item per cycle. Depth is set by the divider, which
// resolves four quotient bits per stage over a 44-bit padded numerator.
// Stages: input decode and simple ops, multiplier and divider set-up,
// divider stages (multiply rounding rides in the first), final sign/saturate.
// Reset clears only the valid bits; no item in flight survives it.
// Rounding is half away from zero; out-of-range results saturate and set
// overflow; a divide by zero gives zero and sets divide_by_zero.
module q24_8_fixed_point_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  q248alu_pkg::req_t req,
    output logic              done,
    output q248alu_pkg::rsp_t rsp
);
    import q248alu_pkg::*;

    logic take;

    // Stage A: decode, compare, simple ops
    logic                     a_valid_reg;
    sb_t                      a_sb_reg;
    sb_t                      a_sb_next;
    logic [DATA_W-1:0]        a_mag_a_reg;
    logic [DATA_W-1:0]        a_mag_b_reg;
    logic [DATA_W-1:0]        mag_a_next;
    logic [DATA_W-1:0]        mag_b_next;

    // Stage B: product and divider set-up
    logic                     b_valid_reg;
    sb_t                      b_sb_reg;
    logic [WIDE_W-1:0]        b_prod_reg;
    div_state_t               b_div_reg;
    div_state_t               b_div_next;

    // Side band alongside the divider
    logic                     sb_valid_reg [DIV_STAGES];
    sb_t                      sb_reg [DIV_STAGES];
    sb_t                      sb0_next;

    logic                     div_valid;
    div_state_t               div_out;

    logic                     out_valid_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    assign busy = 1'b0;
    assign take = start && !busy;

    always_comb
    begin
        logic signed [WIDE_W-1:0] a_w;
        logic signed [WIDE_W-1:0] b_w;
        sat_t s;
        a_w = WIDE_W'(req.operand_a);
        b_w = WIDE_W'(req.operand_b);
        mag_a_next = req.operand_a[DATA_W-1] ? DATA_W'(-req.operand_a) : req.operand_a;
        mag_b_next = req.operand_b[DATA_W-1] ? DATA_W'(-req.operand_b) : req.operand_b;
        a_sb_next.op  = req.req_type;
        a_sb_next.neg = req.operand_a[DATA_W-1] ^ req.operand_b[DATA_W-1];
        a_sb_next.lt  = req.operand_a < req.operand_b;
        a_sb_next.eq  = req.operand_a == req.operand_b;
        a_sb_next.gt  = req.operand_a > req.operand_b;
        a_sb_next.dz  = 1'b0;
        s.val = '0;
        s.ovf = 1'b0;
        unique case (req.req_type)
            OP_ADD:      s = saturate(a_w + b_w);
            OP_SUB:      s = saturate(a_w - b_w);
            OP_INC:      s = saturate(a_w + WIDE_W'(1));
            OP_DEC:      s = saturate(a_w - WIDE_W'(1));
            OP_MIN:      s.val = a_sb_next.lt ? req.operand_a : req.operand_b;
            OP_MAX:      s.val = a_sb_next.gt ? req.operand_a : req.operand_b;
            OP_TO_INT:   s.val = req.operand_a >>> FRAC_BITS;
            OP_FROM_INT: s = saturate(a_w <<< FRAC_BITS);
            OP_DIV:      a_sb_next.dz = (req.operand_b == '0);
            default:     s.val = '0;
        endcase
        a_sb_next.res = s.val;
        a_sb_next.ovf = s.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= take;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= sb_valid_reg[DIV_STAGES-1];
        end
    end

    // Divider operands: (2n + d) / 2d gives round-half-away of n / d
    always_comb
    begin
        logic [NUM_W-1:0] n2;
        n2 = NUM_W'({a_mag_a_reg, {FRAC_BITS{1'b0}}, 1'b0}) + NUM_W'(a_mag_b_reg);
        b_div_next.num = NUM_PAD_W'(n2);
        b_div_next.den = {a_mag_b_reg, 1'b0};
        b_div_next.rem = '0;
        b_div_next.quo = '0;
    end

    always_ff @(posedge clk)
    begin
        a_sb_reg    <= a_sb_next;
        a_mag_a_reg <= mag_a_next;
        a_mag_b_reg <= mag_b_next;
        b_sb_reg    <= a_sb_reg;
        b_prod_reg  <= WIDE_W'(a_mag_a_reg) * WIDE_W'(a_mag_b_reg);
        b_div_reg   <= b_div_next;
    end

    // Multiply rounding and saturation folds into the first side-band stage
    always_comb
    begin
        logic [WIDE_W-1:0]        q;
        logic signed [WIDE_W-1:0] sv;
        sat_t s;
        q  = (b_prod_reg + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        sv = b_sb_reg.neg ? -$signed(q) : $signed(q);
        s  = saturate(sv);
        sb0_next = b_sb_reg;
        if (b_sb_reg.op == OP_MUL)
        begin
            sb0_next.res = s.val;
            sb0_next.ovf = s.ovf;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_sb
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sb_valid_reg[s] <= 1'b0;
            else
                sb_valid_reg[s] <= (s == 0) ? b_valid_reg : sb_valid_reg[(s == 0) ? 0 : s-1];
        end

        always_ff @(posedge clk)
        begin
            sb_reg[s] <= (s == 0) ? sb0_next : sb_reg[(s == 0) ? 0 : s-1];
        end
    end

    q248alu_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_state  (b_div_reg),
        .out_valid (div_valid),
        .out_state (div_out)
    );

    // Final stage: sign and saturate the quotient, pick the result
    always_comb
    begin
        sb_t                      sb;
        logic signed [WIDE_W-1:0] qv;
        sat_t s;
        sb = sb_reg[DIV_STAGES-1];
        qv = $signed(WIDE_W'(div_out.quo));
        s  = saturate(sb.neg ? -qv : qv);
        rsp_next.result_value   = sb.res;
        rsp_next.overflow       = sb.ovf;
        rsp_next.divide_by_zero = sb.dz;
        rsp_next.is_less        = sb.lt;
        rsp_next.is_equal       = sb.eq;
        rsp_next.is_greater     = sb.gt;
        if (sb.op == OP_DIV)
        begin
            if (sb.dz)
            begin
                rsp_next.result_value = '0;
                rsp_next.overflow     = 1'b0;
            end
            else
            begin
                rsp_next.result_value = s.val;
                rsp_next.overflow     = s.ovf;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = out_valid_reg;
    assign rsp  = rsp_reg;

`include "q24_8_fixed_point_alu_assert.svh"

    `Q248_ASSERT(a_align, sb_valid_reg[DIV_STAGES-1], div_valid,
        "side band and divider out of step")
    `Q248_ASSERT(a_cmp_onehot, done, $onehot({rsp.is_less, rsp.is_equal, rsp.is_greater}),
        "compare flags not one-hot")
    `Q248_ASSERT(a_dz_zero, done && rsp.divide_by_zero,
        (rsp.result_value == '0) && !rsp.overflow, "divide by zero result not clean")

endmodule

FILE: rtl/q248alu_divider.sv
module q248alu_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  q248alu_pkg::div_state_t in_state,
    output logic                    out_valid,
    output q248alu_pkg::div_state_t out_state
);
    import q248alu_pkg::*;

    logic       valid_reg [DIV_STAGES];
    div_state_t state_reg [DIV_STAGES];
    div_state_t state_next [DIV_STAGES];

    // Restoring division, BITS_PER_STAGE quotient bits per stage
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        always_comb
        begin
            div_state_t st;
            logic [DEN_W:0] trial;
            if (s == 0)
                st = in_state;
            else
                st = state_reg[(s == 0) ? 0 : s-1];
            for (int k = 0; k < BITS_PER_STAGE; k++)
            begin
                trial = {st.rem, st.num[NUM_PAD_W-1]};
                st.num = {st.num[NUM_PAD_W-2:0], 1'b0};
                if (trial >= {1'b0, st.den})
                begin
                    trial  = trial - {1'b0, st.den};
                    st.quo = {st.quo[NUM_PAD_W-2:0], 1'b1};
                end
                else
                begin
                    st.quo = {st.quo[NUM_PAD_W-2:0], 1'b0};
                end
                st.rem = trial[DEN_W-1:0];
            end
            state_next[s] = st;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s-1];
        end

        always_ff @(posedge clk)
        begin
            state_reg[s] <= state_next[s];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_state = state_reg[DIV_STAGES-1];

`include "q24_8_fixed_point_alu_assert.svh"

    `Q248_ASSERT_NEXT(a_div_enter, in_valid, valid_reg[0], "divider dropped an entry")
    `Q248_ASSERT(a_div_rem, out_valid && (out_state.den != '0),
        out_state.rem < out_state.den, "remainder not below divisor")
    `Q248_ASSERT(a_div_den, out_valid && (out_state.den != '0),
        out_state.den[0] == 1'b0, "divisor not doubled")

endmodule

FILE: tb/tb_q24_8_fixed_point_alu.sv
`timescale 1ns / 1ps

module tb_q24_8_fixed_point_alu;
    import q248alu_pkg::*;

    // Drain margin on top of the ALU latency.
    localparam int DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // Expected responses, oldest first
    rsp_t   pending_rsp[$];
    int     error_count;
    longint cycle_count;
    int     idle_pct;

    q24_8_fixed_point_alu dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Saturate a wide value into 32 bits, flagging overflow
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
                                                   inout logic ovf);
        if (v > 64'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Exact fixed-point behaviour of one operation
    function automatic rsp_t alu_predict(input req_t r);
        rsp_t o;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic signed [63:0] s;
        logic neg;
        logic ovf;
        a   = 64'(r.operand_a);
        b   = 64'(r.operand_b);
        ma  = (a < 0) ? 64'(-a) : 64'(a);
        mb  = (b < 0) ? 64'(-b) : 64'(b);
        neg = (a < 0) != (b < 0);
        ovf = 1'b0;
        o   = '0;
        case (r.req_type)
            OP_ADD:      o.result_value = clamp32(a + b, ovf);
            OP_SUB:      o.result_value = clamp32(a - b, ovf);
            OP_MUL:
            begin
                q = (ma * mb + 64'd128) >> 8;
                s = neg ? -$signed(q) : $signed(q);
                o.result_value = clamp32(s, ovf);
            end
            OP_DIV:
            begin
                if (b == 0)
                    o.divide_by_zero = 1'b1;
                else
                begin
                    q = (2 * (ma << 8) + mb) / (2 * mb);
                    s = neg ? -$signed(q) : $signed(q);
                    o.result_value = clamp32(s, ovf);
                end
            end
            OP_INC:      o.result_value = clamp32(a + 1, ovf);
            OP_DEC:      o.result_value = clamp32(a - 1, ovf);
            OP_MIN:      o.result_value = (a < b) ? r.operand_a : r.operand_b;
            OP_MAX:      o.result_value = (a > b) ? r.operand_a : r.operand_b;
            OP_TO_INT:   o.result_value = r.operand_a >>> 8;
            OP_FROM_INT: o.result_value = clamp32(a * 256, ovf);
            default:     o.result_value = '0;
        endcase
        o.overflow   = ovf;
        o.is_less    = a < b;
        o.is_equal   = a == b;
        o.is_greater = a > b;
        return o;
    endfunction

    // Present one item, holding start until it transfers; idle cycles
    // beforehand according to idle_pct. Called just after a falling edge.
    task automatic send_item(input logic [3:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        req_t r;
        r.req_type  = op;
        r.operand_a = a;
        r.operand_b = b;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rsp.push_back(alu_predict(r));
        @(negedge clk);
    endtask

    task automatic finish_burst();
        start <= 1'b0;
        @(negedge clk);
    endtask

    // Interesting operand values, weighted toward edges
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(8)) - 32'd4;
            3: return 32'($signed($urandom_range(4095)) - 2048);
            4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            5: return 32'($urandom) >>> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Extremes of each field, every operation, saturation, divide by zero,
    // unused codes and rounding ties
    task automatic test_directed();
        logic [3:0] op;
        idle_pct = 0;
        for (int i = 0; i < 16; i++)
        begin
            op = 4'(i);
            send_item(op, 32'h7FFF_FFFF, 32'h8000_0000);
        end
        send_item(OP_DIV, 32'h0000_0100, 32'h0);
        send_item(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(OP_MUL, 32'h0000_0001, 32'h0000_0080); // tie rounds up
        send_item(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080); // tie away from zero
        send_item(OP_DIV, 32'h0000_0001, 32'h0000_0200);
        send_item(OP_INC, 32'h7FFF_FFFF, 32'h0);
        send_item(OP_DEC, 32'h8000_0000, 32'h0);
        send_item(OP_TO_INT, 32'hFFFF_FF01, 32'hFFFF_FF01);
        send_item(OP_FROM_INT, 32'hFF80_0000, 32'h0);
        finish_burst();
    endtask

    // Random items at a given sender idle rate
    task automatic test_random(input int count, input int pct);
        logic [3:0] op;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                           : 4'($urandom_range(9));
            if (op == OP_DIV && $urandom_range(9) == 0)
                send_item(op, pick_operand(), 32'h0);
            else
                send_item(op, pick_operand(), pick_operand());
        end
        finish_burst();
    endtask

    // Sender holds off until every outstanding result has arrived
    task automatic test_drain_pause();
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    // Response checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, rsp);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp !== want)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, rsp);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("q24_8_fixed_point_alu regression: fail");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        idle_pct    = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(300, 0);
        test_drain_pause();
        test_random(280, 57);
        test_random(280, 0);
        test_random(270, 33);

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("q24_8_fixed_point_alu regression: pass");
        else
            $display("q24_8_fixed_point_alu regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/q248alu_pkg.sv
rtl/q248alu_divider.sv
rtl/q24_8_fixed_point_alu.sv
tb/tb_q24_8_fixed_point_alu.sv
